/* rtl/sql_placeholder_rewriter_top_defines.svh */
// Assertion macros used by the checked top-level RTL file.
`ifndef SQL_PLACEHOLDER_REWRITER_TOP_DEFINES_SVH
`define SQL_PLACEHOLDER_REWRITER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spr check failed");

`endif

/* rtl/spr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package spr_pkg;

    localparam int SPR_QUEUE_DEPTH = 4;
    localparam int IDX_W           = 3;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_BIND,
        KIND_PLACE
    } spr_kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic [7:0] next_char;
        logic       first_of_query;
    } spr_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } spr_out_t;

    typedef struct packed {
        spr_kind_t   kind;
        logic        close_bind;
        logic [7:0]  ch;
        logic [19:0] digits;
        logic [2:0]  ndigits;
    } spr_desc_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
               (c == 8'h0C) || (c == 8'h0D);
    endfunction

    function automatic logic is_closer(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_RPAREN) || (c == CH_SEMI) ||
               (c == CH_COLON) || (c == CH_EQUAL);
    endfunction

    // Five-digit BCD increment.
    function automatic logic [19:0] bcd_inc(input logic [19:0] v);
        logic [19:0] r;
        logic        carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < 5; i++) begin
            if (carry) begin
                if (r[i*4 +: 4] == 4'd9) begin
                    r[i*4 +: 4] = 4'd0;
                end else begin
                    r[i*4 +: 4] = r[i*4 +: 4] + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [2:0] bcd_ndigits(input logic [19:0] v);
        if (v[19:16] != 4'd0) return 3'd5;
        if (v[15:12] != 4'd0) return 3'd4;
        if (v[11:8] != 4'd0)  return 3'd3;
        if (v[7:4] != 4'd0)   return 3'd2;
        return 3'd1;
    endfunction

endpackage
`default_nettype wire

/* rtl/spr_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module spr_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire spr_pkg::spr_in_t   in_data,
    input  wire logic               q_full,
    output logic                    push,
    output spr_pkg::spr_desc_t      push_desc
);
    import spr_pkg::*;

    logic        in_quotes_reg, in_quotes_next;
    logic        in_bind_reg, in_bind_next;
    logic [15:0] count_reg, count_next;
    logic [19:0] bcd_reg, bcd_next;

    logic        iq0, ib0, iq1, close_b, opener, is_ph;
    logic [15:0] cnt0;
    logic [19:0] bcd0;
    logic [7:0]  c;

    assign push = in_valid && !q_full;
    assign c    = in_data.char_in;

    always_comb
    begin
        iq0  = in_data.first_of_query ? 1'b0  : in_quotes_reg;
        ib0  = in_data.first_of_query ? 1'b0  : in_bind_reg;
        cnt0 = in_data.first_of_query ? 16'd0 : count_reg;
        bcd0 = in_data.first_of_query ? 20'd0 : bcd_reg;

        iq1     = (c == CH_QUOTE) ? !iq0 : iq0;
        close_b = !iq1 && ib0 && (is_space(c) || is_closer(c));
        opener  = !iq1 && ((c == CH_QMARK) || (c == CH_COLON) || (c == CH_DOLLAR) ||
                           ((c == CH_AT) && (in_data.next_char != CH_AT)));
        is_ph   = opener && (c == CH_QMARK);

        in_bind_next = (close_b ? 1'b0 : ib0) || (opener && !is_ph);
        in_quotes_next = iq1;
        count_next = cnt0;
        bcd_next   = bcd0;
        if (is_ph) begin
            count_next = cnt0 + 16'd1;
            // Decimal image wraps together with the binary count.
            bcd_next   = (cnt0 == 16'hFFFF) ? 20'd0 : bcd_inc(bcd0);
        end

        push_desc.kind       = !opener ? KIND_PASS : (is_ph ? KIND_PLACE : KIND_BIND);
        push_desc.close_bind = close_b;
        push_desc.ch         = c;
        push_desc.digits     = bcd0;
        push_desc.ndigits    = bcd_ndigits(bcd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quotes_reg <= 1'b0;
            in_bind_reg   <= 1'b0;
            count_reg     <= 16'd0;
            bcd_reg       <= 20'd0;
        end
        else if (push)
        begin
            in_quotes_reg <= in_quotes_next;
            in_bind_reg   <= in_bind_next;
            count_reg     <= count_next;
            bcd_reg       <= bcd_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/spr_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module spr_queue #(
    parameter int Depth = spr_pkg::SPR_QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire spr_pkg::spr_desc_t  push_desc,
    input  wire logic                pop,
    output logic                     full,
    output logic                     empty,
    output spr_pkg::spr_desc_t       head
);
    import spr_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

    spr_desc_t         slot_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CntW'(Depth));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CntW'(push) - CntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= push_desc;
    end

endmodule
`default_nettype wire

/* rtl/spr_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module spr_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire spr_pkg::spr_desc_t  head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output spr_pkg::spr_out_t        out_data
);
    import spr_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    spr_out_t         out_data_reg;

    logic             load, last;
    logic [IDX_W-1:0] last_idx, j, k, di;
    logic [7:0]       cur_byte;
    logic [3:0]       digit;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        j  = idx_reg - IDX_W'(head.close_bind);
        k  = j - IDX_W'(2);
        di = head.ndigits - IDX_W'(1) - k;

        unique case (di)
            3'd0:    digit = head.digits[3:0];
            3'd1:    digit = head.digits[7:4];
            3'd2:    digit = head.digits[11:8];
            3'd3:    digit = head.digits[15:12];
            3'd4:    digit = head.digits[19:16];
            default: digit = 4'd0;
        endcase

        unique case (head.kind)
            KIND_PASS:  last_idx = IDX_W'(head.close_bind);
            KIND_BIND:  last_idx = IDX_W'(head.close_bind) + IDX_W'(1);
            KIND_PLACE: last_idx = head.ndigits + IDX_W'(2);
            default:    last_idx = '0;
        endcase

        if (head.close_bind && (idx_reg == '0)) begin
            cur_byte = CH_RPAREN;
        end else begin
            unique case (head.kind)
                KIND_PASS:  cur_byte = head.ch;
                KIND_BIND:  cur_byte = (j == '0) ? CH_DOLLAR : CH_LPAREN;
                KIND_PLACE:
                begin
                    if (j == '0)           cur_byte = CH_DOLLAR;
                    else if (j == 3'd1)    cur_byte = CH_LPAREN;
                    else if (j == last_idx) cur_byte = CH_RPAREN;
                    else                   cur_byte = CH_ZERO + {4'd0, digit};
                end
                default:    cur_byte = head.ch;
            endcase
        end

        load = !empty && (!out_valid_reg || !out_stall);
        last = (idx_reg == last_idx);
        pop  = load && last;

        idx_next = idx_reg;
        if (load) idx_next = last ? '0 : idx_reg + IDX_W'(1);

        // Hold a stalled byte, drop it once taken unless another replaces it.
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.out_byte    <= cur_byte;
            out_data_reg.last_of_run <= last;
        end
    end

endmodule
`default_nettype wire

/* rtl/sql_placeholder_rewriter_top.sv */
// A request passes through its queue entry, then the output register, before the
// consumer can take its first output byte.
// Throughput: one output byte per cycle while text_stall is low; a request expands to
// 1 to 8 output bytes, sent through the single byte-wide output register.
// The request queue absorbs up to QueueDepth requests while long expansions drain.
// Reset (rst_n low, asynchronous) clears quote, bind and count state and empties
// the queue and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "sql_placeholder_rewriter_top_defines.svh"
module sql_placeholder_rewriter_top #(
    parameter int QueueDepth = spr_pkg::SPR_QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               query_valid,
    output logic                    query_stall,
    input  wire spr_pkg::spr_in_t   query,
    output logic                    text_valid,
    input  wire logic               text_stall,
    output spr_pkg::spr_out_t       text
);
    import spr_pkg::*;

    logic      push, pop, q_full, q_empty;
    spr_desc_t push_desc, head;

    assign query_stall = q_full;

    spr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (query_valid),
        .in_data   (query),
        .q_full    (q_full),
        .push      (push),
        .push_desc (push_desc)
    );

    spr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    spr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (text_valid),
        .out_stall (text_stall),
        .out_data  (text)
    );

    `SPR_ASSERT_NOW(a_pop_not_empty, pop, !q_empty)
    `SPR_ASSERT_NEXT(a_push_fills, push && q_empty && !pop, !q_empty)
    `SPR_ASSERT_NEXT(a_pop_marks_last, pop, text_valid && text.last_of_run)
    `SPR_ASSERT_NEXT(a_empty_idle_drops, !text_stall && q_empty, !text_valid || $past(push))

endmodule
`default_nettype wire
